// File: rtl/core/mtp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the tone table of the motion armed tune player
// no dependencies

package mtp_pkg;

	// tune length default and tone table
	localparam int TUNE_STEPS_DEF = 18;
	localparam int TABLE_LEN      = 18;
	localparam int TONE_W         = 12;
	localparam int TONE_SEL_W     = $clog2(TABLE_LEN);
	localparam int TONE_IDX_W     = 6;

	localparam logic [TONE_W-1:0] TONE_TABLE [TABLE_LEN] = '{
		12'd0,    12'd1975, 12'd2637, 12'd0,    12'd0,    12'd0,
		12'd0,    12'd1318, 12'd1568, 12'd2637, 12'd2093, 12'd2349,
		12'd3136, 12'd3136, 12'd3136, 12'd0,    12'd0,    12'd0
	};

	// field widths
	localparam int ACCEL_W = 12;
	localparam int CLUX_W  = 23;
	localparam int LUX_W   = 17;
	localparam int SIDE_W  = 11;

	// whole lux = centilux / 100 as multiply by rounded-up reciprocal
	localparam int                  LUX_RECIP_W = 24;
	localparam logic [LUX_RECIP_W-1:0] LUX_RECIP = 24'd10737419;
	localparam int                  LUX_SHIFT   = 30;
	localparam int                  LUX_PROD_W  = CLUX_W + LUX_RECIP_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIDE_LIMIT  = 2'd0,
		CFG_VERT_LOW    = 2'd1,
		CFG_VERT_HIGH   = 2'd2,
		CFG_LIGHT_LIMIT = 2'd3
	} cfg_reg_e;

	localparam logic [SIDE_W-1:0]         SIDE_LIMIT_RST  = 11'd175;
	localparam logic signed [ACCEL_W-1:0] VERT_LOW_RST    = -12'sd225;
	localparam logic [SIDE_W-1:0]         VERT_HIGH_RST   = 11'd150;
	localparam logic [LUX_W-1:0]          LIGHT_LIMIT_RST = 17'd300;

	typedef struct packed {
		logic [SIDE_W-1:0]         side_motion_limit;
		logic signed [ACCEL_W-1:0] vertical_low_limit;
		logic [SIDE_W-1:0]         vertical_high_limit;
		logic [LUX_W-1:0]          light_jump_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_side;
		logic signed [ACCEL_W-1:0] accel_front;
		logic signed [ACCEL_W-1:0] accel_vertical;
		logic [CLUX_W-1:0]         light_centilux;
		logic                      light_ok;
	} tick_t;

	typedef struct packed {
		logic              buzzer_on;
		logic [TONE_W-1:0] tone_hz;
		logic              is_active;
	} result_t;

	// pre-processed tick handed to the tune core
	typedef struct packed {
		logic             motion;
		logic             light_ok;
		logic [LUX_W-1:0] lux;
	} front_t;

	function automatic logic [TONE_W-1:0] tone_at(input logic [TONE_IDX_W-1:0] beat);
		logic [TONE_W-1:0] tone;
		tone = '0;
		if (beat < TONE_IDX_W'(TABLE_LEN))
			tone = TONE_TABLE[beat[TONE_SEL_W-1:0]];
		return tone;
	endfunction

endpackage

// File: rtl/core/mtp_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file of the motion armed tune player
// depends on mtp_pkg

module mtp_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mtp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mtp_pkg::CFG_DATA_W-1:0] wr_data,
	output mtp_pkg::cfg_t                  cfg
);
	import mtp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_motion_limit   <= SIDE_LIMIT_RST;
			cfg_q.vertical_low_limit  <= VERT_LOW_RST;
			cfg_q.vertical_high_limit <= VERT_HIGH_RST;
			cfg_q.light_jump_limit    <= LIGHT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_e'(wr_index))
				CFG_SIDE_LIMIT:  cfg_q.side_motion_limit   <= wr_data[SIDE_W-1:0];
				CFG_VERT_LOW:    cfg_q.vertical_low_limit  <= wr_data[ACCEL_W-1:0];
				CFG_VERT_HIGH:   cfg_q.vertical_high_limit <= wr_data[SIDE_W-1:0];
				CFG_LIGHT_LIMIT: cfg_q.light_jump_limit    <= wr_data[LUX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mtp_front.sv
`timescale 1ns / 1ps
// second stage: motion window check and centilux to whole lux scaling
// depends on mtp_pkg

module mtp_front (
	input  logic           clk,
	input  logic           load,
	input  mtp_pkg::tick_t tick_s1,
	input  mtp_pkg::cfg_t  cfg,
	output mtp_pkg::front_t front_s2
);
	import mtp_pkg::*;

	logic signed [ACCEL_W:0] side_hi, side_lo, vert_hi, ax, ay, az;
	logic                    motion;
	logic [LUX_PROD_W-1:0]   lux_prod;
	front_t                  front_d;

	always_comb begin
		side_hi = $signed({2'b00, cfg.side_motion_limit});
		side_lo = -side_hi;
		vert_hi = $signed({2'b00, cfg.vertical_high_limit});
		ax      = $signed({tick_s1.accel_side[ACCEL_W-1], tick_s1.accel_side});
		ay      = $signed({tick_s1.accel_front[ACCEL_W-1], tick_s1.accel_front});
		az      = $signed({tick_s1.accel_vertical[ACCEL_W-1], tick_s1.accel_vertical});
		motion  = (ax < side_lo) || (ax > side_hi) ||
		          (ay < side_lo) || (ay > side_hi) ||
		          (tick_s1.accel_vertical < cfg.vertical_low_limit) ||
		          (az > vert_hi);
	end

	// exact for every 23-bit reading
	assign lux_prod = LUX_PROD_W'(tick_s1.light_centilux) * LUX_PROD_W'(LUX_RECIP);

	always_comb begin
		front_d.motion   = motion;
		front_d.light_ok = tick_s1.light_ok;
		front_d.lux      = lux_prod[LUX_SHIFT +: LUX_W];
	end

	always_ff @(posedge clk) begin
		if (load)
			front_s2 <= front_d;
	end

endmodule

// File: rtl/core/mtp_tune_core.sv
`timescale 1ns / 1ps
// mode, tick counter, buzzer and light jump state; these registers are the result
// depends on mtp_pkg

module mtp_tune_core #(
	parameter int TUNE_STEPS = mtp_pkg::TUNE_STEPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  mtp_pkg::front_t  front_s2,
	input  mtp_pkg::cfg_t    cfg,
	output mtp_pkg::result_t result
);
	import mtp_pkg::*;

	localparam int CYCLE = 2 * TUNE_STEPS;
	localparam int CNT_W = $clog2(CYCLE);

	logic              active_q, active_d;
	logic [CNT_W-1:0]  tick_q, tick_d;
	logic [LUX_W-1:0]  last_lux_q, last_lux_d;
	logic              lux_known_q, lux_known_d;
	logic              buzz_q, buzz_d;
	logic [TONE_W-1:0] tone_q, tone_d;

	logic [CNT_W:0]    cnt_inc;
	logic [CNT_W-1:0]  cnt, beat;
	logic [TONE_W-1:0] tone_now;
	logic [LUX_W-1:0]  base_lux, lux_diff;

	always_comb begin
		cnt_inc  = {1'b0, tick_q} + 1'b1;
		cnt      = (cnt_inc == (CNT_W+1)'(CYCLE)) ? '0 : cnt_inc[CNT_W-1:0];
		beat     = (tick_q >= CNT_W'(TUNE_STEPS)) ? tick_q - CNT_W'(TUNE_STEPS) : tick_q;
		tone_now = tone_at(TONE_IDX_W'(beat));
		// first reading stands in as its own predecessor
		base_lux = lux_known_q ? last_lux_q : front_s2.lux;
		lux_diff = (front_s2.lux >= base_lux) ? front_s2.lux - base_lux
		                                      : base_lux - front_s2.lux;
	end

	always_comb begin
		active_d    = active_q;
		tick_d      = cnt;
		last_lux_d  = last_lux_q;
		lux_known_d = lux_known_q;
		buzz_d      = buzz_q;
		tone_d      = tone_q;
		if (!active_q) begin
			if (front_s2.motion) begin
				tick_d   = '0;
				active_d = 1'b1;
			end
		end else begin
			if (cnt > CNT_W'(TUNE_STEPS)) begin
				buzz_d = 1'b0;
			end else if (buzz_q && (tone_now == '0)) begin
				buzz_d = 1'b0;
			end else begin
				buzz_d = 1'b1;
				tone_d = tone_now;
			end
			if (cnt[0] && front_s2.light_ok) begin
				if (lux_diff > cfg.light_jump_limit) begin
					lux_known_d = 1'b0;
					last_lux_d  = '0;
					tick_d      = '0;
					active_d    = 1'b0;
					buzz_d      = 1'b0;
				end else begin
					lux_known_d = 1'b1;
					last_lux_d  = front_s2.lux;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			tick_q      <= '0;
			last_lux_q  <= '0;
			lux_known_q <= 1'b0;
			buzz_q      <= 1'b0;
			tone_q      <= '0;
		end else if (fire) begin
			active_q    <= active_d;
			tick_q      <= tick_d;
			last_lux_q  <= last_lux_d;
			lux_known_q <= lux_known_d;
			buzz_q      <= buzz_d;
			tone_q      <= tone_d;
		end
	end

	always_comb begin
		result.buzzer_on = buzz_q;
		result.tone_hz   = tone_q;
		result.is_active = active_q;
	end

endmodule

// File: rtl/core/motion_armed_tune_player.sv
`timescale 1ns / 1ps
// top level of the motion armed tune player: input register, flow control, config port
// depends on mtp_pkg, mtp_cfg_regs, mtp_front, mtp_tune_core
//
//  channel  | handshake                     | word
//  ---------+-------------------------------+----------------------------------
//  tick     | tick_valid / tick_stall       | tick   (mtp_pkg::tick_t)
//  result   | result_valid / result_stall   | result (mtp_pkg::result_t)
//  config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one tick word is taken every cycle while tick_stall is low; its result word then passes
// the input register, the lux scaling stage and the state/result register
// the stage chain is the only latency; the state update is combinational into the state/result register
// arst_n clears mode, counter, lux memory, buzzer, tone and config to reset values
// a stalled result holds; bubbles still fill behind it, so tick_stall rises only
// when all three stages hold a word

module motion_armed_tune_player #(
	parameter int TUNE_STEPS = mtp_pkg::TUNE_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	output logic                           tick_stall,
	input  mtp_pkg::tick_t                 tick,
	output logic                           result_valid,
	input  logic                           result_stall,
	output mtp_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mtp_pkg::*;

	cfg_t   cfg;
	tick_t  tick_s1;
	front_t front_s2;
	logic   valid_s1, valid_s2, result_valid_q;
	logic   adv_out, adv_s2, adv_s1;

	// config writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	mtp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// each stage moves on when the one after it is empty or moving
	always_comb begin
		adv_out    = !result_valid_q || !result_stall;
		adv_s2     = !valid_s2 || adv_out;
		adv_s1     = !valid_s1 || adv_s2;
		tick_stall = !adv_s1;
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1)
			tick_s1 <= tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= tick_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_out)
				result_valid_q <= valid_s2;
		end
	end

	// motion check and lux scaling
	mtp_front u_front (
		.clk      (clk),
		.load     (adv_s2),
		.tick_s1  (tick_s1),
		.cfg      (cfg),
		.front_s2 (front_s2)
	);

	// state update; fires once per word leaving the second stage
	mtp_tune_core #(
		.TUNE_STEPS (TUNE_STEPS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (valid_s2 && adv_out),
		.front_s2 (front_s2),
		.cfg      (cfg),
		.result   (result)
	);

	assign result_valid = result_valid_q;

endmodule

// File: rtl/core/mtp_checker.sv
`timescale 1ns / 1ps
// port-level checks of the motion armed tune player, bound to the top level
// depends on mtp_pkg and motion_armed_tune_player

module mtp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             tick_valid,
	input logic             tick_stall,
	input logic             result_valid,
	input logic             result_stall,
	input mtp_pkg::result_t result
);
	import mtp_pkg::*;

	logic [2:0] inflight_q;

	// words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 3'(tick_valid && !tick_stall)
			                         - 3'(result_valid && !result_stall);
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_active |-> !result.buzzer_on)
		else $error("buzzer running while idle");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> inflight_q == 3'd3)
		else $error("tick stalled with free stage");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid |-> inflight_q != 3'd0) and (inflight_q <= 3'd3))
		else $error("result word without matching tick word");

endmodule

bind motion_armed_tune_player mtp_checker u_mtp_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the motion armed tune player: directed table, then random phases
// under several register settings; depends on mtp_pkg and motion_armed_tune_player

module tb_top;
	import mtp_pkg::*;

	// tune length the dut is built with, and the scaled input ceilings
	localparam int TUNE_LEN    = 18;
	localparam int CLUX_MAX    = 8388607;
	localparam int LUX_MAX     = 83886;
	localparam int ACCEL_MAX   = 1600;
	localparam int PHASES      = 8;
	localparam int PHASE_TICKS = 155;
	localparam int SETTLE_CYC  = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		tick_t   word;
		bit      typed;
		result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  tick_valid   = 1'b0;
	logic                  tick_stall;
	tick_t                 tick         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// tone per beat of the tune, rests are 0 Hz
	int tune_hz [TUNE_LEN] = '{0, 1975, 2637, 0, 0, 0, 0, 1318, 1568, 2637, 2093, 2349,
		3136, 3136, 3136, 0, 0, 0};

	// predictor copy of the register file, at reset values
	int side_lim  = 175;
	int vert_low  = -225;
	int vert_high = 150;
	int jump_lim  = 300;

	// predictor copy of the player state
	bit armed     = 1'b0;
	int tick_cnt  = 0;
	int last_lux  = 0;
	bit lux_known = 1'b0;
	bit buzzing   = 1'b0;
	int tone_now  = 0;

	// register settings per phase; phase 0 keeps the reset values, phases 5 and 6 are drawn
	int set_side [PHASES] = '{175, 0, 1600, 1600, 0, 0, 0, 175};
	int set_vlow [PHASES] = '{-225, 0, -1600, 0, -1600, 0, 0, -225};
	int set_vhigh [PHASES] = '{150, 0, 1600, 1600, 0, 0, 0, 150};
	int set_jump [PHASES] = '{300, 0, 83886, 0, 83886, 0, 0, 300};

	result_t   results_due [$];
	result_t   due_word;
	plan_row_t plan [$];
	int        mismatches = 0;
	int        stall_left = 0;
	int        cycle_cnt  = 0;
	int        room_clux  = 5000;
	bit        bursts_on  = 1'b1;

	motion_armed_tune_player #(
		.TUNE_STEPS(TUNE_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the predicted player by one tick and return the word it should emit
	function automatic result_t advance_tune(tick_t w);
		int      ax, ay, az, beat, nxt, hz, lux, diff;
		result_t r;
		ax   = int'($signed(w.accel_side));
		ay   = int'($signed(w.accel_front));
		az   = int'($signed(w.accel_vertical));
		beat = tick_cnt % TUNE_LEN;
		nxt  = (tick_cnt + 1) % (2 * TUNE_LEN);
		tick_cnt = nxt;
		if (!armed) begin
			// any axis outside its window arms the player and restarts the tune
			if (ax < -side_lim || ax > side_lim || ay < -side_lim || ay > side_lim ||
					az < vert_low || az > vert_high) begin
				tick_cnt = 0;
				armed    = 1'b1;
			end
		end else begin
			hz = (beat < TUNE_LEN) ? tune_hz[beat] : 0;
			// second half of the cycle is silent; a rest silences a running buzzer,
			// otherwise the beat is started, a rest then sounding at 0 Hz
			if (nxt > TUNE_LEN) begin
				buzzing = 1'b0;
			end else if (buzzing && hz == 0) begin
				buzzing = 1'b0;
			end else begin
				buzzing  = 1'b1;
				tone_now = hz;
			end
			// light check on odd counts with a valid reading only
			if (nxt[0] && w.light_ok) begin
				lux = int'(w.light_centilux) / 100;
				if (!lux_known) begin
					last_lux  = lux;
					lux_known = 1'b1;
				end
				diff = lux - last_lux;
				if (diff > jump_lim || diff < -jump_lim) begin
					lux_known = 1'b0;
					last_lux  = 0;
					tick_cnt  = 0;
					armed     = 1'b0;
					buzzing   = 1'b0;
				end else begin
					last_lux = lux;
				end
			end
		end
		r.buzzer_on = buzzing;
		r.tone_hz   = TONE_W'(tone_now);
		r.is_active = armed;
		return r;
	endfunction

	// random tick: quiet or moving accelerometer, drifting light with jumps and sensor errors
	function automatic tick_t next_tick();
		int a [3];
		int k, target, clux;
		bit ok;
		a[0] = int'($urandom_range(0, 2 * side_lim)) - side_lim;
		a[1] = int'($urandom_range(0, 2 * side_lim)) - side_lim;
		a[2] = vert_low + int'($urandom_range(0, vert_high - vert_low));
		if (armed) begin
			// ignored while active, so anything goes
			foreach (a[i])
				a[i] = int'($urandom_range(0, 2 * ACCEL_MAX)) - ACCEL_MAX;
		end else if ($urandom_range(0, 3) == 0) begin
			a[$urandom_range(0, 2)] = int'($urandom_range(0, 2 * ACCEL_MAX)) - ACCEL_MAX;
		end
		k = $urandom_range(0, 39);
		if (k < 2) begin
			room_clux = int'($urandom_range(0, CLUX_MAX));
		end else if (k < 4 && lux_known) begin
			// land just on or just past the jump limit from the last reading
			target = last_lux + ((k == 2) ? 1 : -1) * (jump_lim + int'($urandom_range(0, 1)));
			if (target < 0)
				target = 0;
			if (target > LUX_MAX)
				target = LUX_MAX;
			room_clux = target * 100 + int'($urandom_range(0, 99));
		end else begin
			room_clux += int'($urandom_range(0, 4000)) - 2000;
		end
		if (room_clux < 0)
			room_clux = 0;
		if (room_clux > CLUX_MAX)
			room_clux = CLUX_MAX;
		ok   = ($urandom_range(0, 9) != 0);
		clux = ok ? room_clux : int'($urandom_range(0, CLUX_MAX));
		return '{ACCEL_W'(a[0]), ACCEL_W'(a[1]), ACCEL_W'(a[2]), CLUX_W'(clux), ok};
	endfunction

	function automatic plan_row_t row(int s, int f, int v, int clux, bit ok,
			bit typed, bit b, int hz, bit act);
		plan_row_t p;
		p.word  = '{ACCEL_W'(s), ACCEL_W'(f), ACCEL_W'(v), CLUX_W'(clux), ok};
		p.typed = typed;
		p.want  = '{b, TONE_W'(hz), act};
		return p;
	endfunction

	// present one tick word, optionally after an idle burst, and hold it until taken
	task automatic send_tick(tick_t w, bit typed, result_t want);
		result_t due;
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= w;
		do @(posedge clk); while (tick_stall);
		due = advance_tune(w);
		results_due.push_back(typed ? want : due);
	endtask

	// one register write; valid stays high so back-to-back writes need no gap
	task automatic cfg_word(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			CFG_SIDE_LIMIT:  side_lim  = int'(d[SIDE_W-1:0]);
			CFG_VERT_LOW:    vert_low  = int'($signed(d[ACCEL_W-1:0]));
			CFG_VERT_HIGH:   vert_high = int'(d[SIDE_W-1:0]);
			CFG_LIGHT_LIMIT: jump_lim  = int'(d[LUX_W-1:0]);
			default: ;
		endcase
	endtask

	// wait for every outstanding result word, then let the pipeline run dry
	task automatic settle();
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// result side: check each taken word against the oldest prediction, stall in bursts
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: result word with nothing expected: %p", $time, result);
				mismatches++;
			end else begin
				due_word = results_due.pop_front();
				if (result.buzzer_on !== due_word.buzzer_on) begin
					$display("%0t: buzzer_on expected %0d got %0d", $time,
						due_word.buzzer_on, result.buzzer_on);
					mismatches++;
				end
				if (result.tone_hz !== due_word.tone_hz) begin
					$display("%0t: tone_hz expected %0d got %0d", $time,
						due_word.tone_hz, result.tone_hz);
					mismatches++;
				end
				if (result.is_active !== due_word.is_active) begin
					$display("%0t: is_active expected %0d got %0d", $time,
						due_word.is_active, result.is_active);
					mismatches++;
				end
			end
		end
		if (!bursts_on) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timed out", $time);
			$display("** motion_armed_tune_player: FAILED **");
			$finish;
		end
	end

	initial begin
		// reset held low from time zero, released on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset settings: window edges, tune start, lux boundary and jumps
		plan.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 0));
		plan.push_back(row(175, -175, 150, 0, 1, 1, 0, 0, 0));         // on the window edge
		plan.push_back(row(-175, 175, -225, CLUX_MAX, 1, 1, 0, 0, 0));
		plan.push_back(row(0, -176, 0, 5000, 1, 1, 0, 0, 1));          // front just outside
		plan.push_back(row(1600, 1600, 1600, 5000, 1, 0, 0, 0, 0));    // first reading, rest at 0 Hz
		plan.push_back(row(-1600, -1600, -1600, 5000, 1, 0, 0, 0, 0));
		plan.push_back(row(0, 0, 0, 35099, 1, 0, 0, 0, 0));            // change of exactly the limit
		plan.push_back(row(0, 0, 0, 35099, 1, 0, 0, 0, 0));            // rest stops the buzzer
		plan.push_back(row(0, 0, 0, CLUX_MAX, 0, 0, 0, 0, 0));         // sensor error ignored
		plan.push_back(row(0, 0, 0, 4999, 1, 0, 0, 0, 0));
		plan.push_back(row(0, 0, 0, 4999, 1, 1, 0, 0, 0));             // one past the limit
		plan.push_back(row(0, 0, 151, 0, 0, 1, 0, 0, 1));              // vertical above window
		plan.push_back(row(0, 0, 0, CLUX_MAX, 1, 0, 0, 0, 0));         // first reading after forget
		plan.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 0));                // even count, no check
		plan.push_back(row(0, 0, 0, 0, 1, 1, 0, 2637, 0));             // full-scale drop
		plan.push_back(row(0, 0, -226, 0, 1, 1, 0, 2637, 1));          // vertical below window
		foreach (plan[i])
			send_tick(plan[i].word, plan[i].typed, plan[i].want);

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				if (p == 5 || p == 6) begin
					set_side[p]  = $urandom_range(0, ACCEL_MAX);
					set_vlow[p]  = -int'($urandom_range(0, ACCEL_MAX));
					set_vhigh[p] = $urandom_range(0, ACCEL_MAX);
					set_jump[p]  = $urandom_range(0, 1) ? $urandom_range(0, 600)
						: $urandom_range(0, LUX_MAX);
				end
				cfg_word(CFG_SIDE_LIMIT, CFG_DATA_W'(set_side[p]));
				cfg_word(CFG_VERT_LOW, CFG_DATA_W'(set_vlow[p] & 'hFFF));
				cfg_word(CFG_VERT_HIGH, CFG_DATA_W'(set_vhigh[p]));
				cfg_word(CFG_LIGHT_LIMIT, CFG_DATA_W'(set_jump[p]));
				cfg_valid <= 1'b0;
			end
			for (int i = 0; i < PHASE_TICKS; i++) begin
				// no idling in the last phase, and a quiet stretch in every other one
				bursts_on = (p != PHASES - 1) && ((i / 40) % 4 != 3);
				send_tick(next_tick(), 1'b0, '0);
			end
			tick_valid <= 1'b0;
		end

		settle();
		if (mismatches == 0)
			$display("** motion_armed_tune_player: PASSED **");
		else
			$display("** motion_armed_tune_player: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/mtp_pkg.sv
rtl/core/mtp_cfg_regs.sv
rtl/core/mtp_front.sv
rtl/core/mtp_tune_core.sv
rtl/core/motion_armed_tune_player.sv
rtl/core/mtp_checker.sv
tb/tb_top.sv
